// ===== sv/vpc_pkg.sv =====
// ----------------------------------------------------------------------------
// vpc_pkg
// Types and constants shared by the vertex projection and clip block.
// ----------------------------------------------------------------------------
package vpc_pkg;

    localparam int DIV_STEPS = 64;
    localparam int NORM_FRAC = 14;
    localparam int NUM_REGS  = 7;

    typedef enum logic [2:0] {
        REG_FOCAL_SCALE    = 3'd0,
        REG_SCREEN_WIDTH   = 3'd1,
        REG_SCREEN_HEIGHT  = 3'd2,
        REG_CLIP_WIDTH     = 3'd3,
        REG_CLIP_HEIGHT    = 3'd4,
        REG_TEXTURE_WIDTH  = 3'd5,
        REG_TEXTURE_HEIGHT = 3'd6,
        REG_UNUSED         = 3'd7
    } t_reg_idx;

    // one lane of the restoring divider
    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] work;
        logic [31:0] d;
        logic        neg;
    } t_div;

    // results that ride alongside the divider
    typedef struct packed {
        logic               z_neg;
        logic signed [31:0] depth;
        logic [7:0]         nbx;
        logic [7:0]         nby;
        logic signed [23:0] tx;
        logic signed [23:0] ty;
    } t_side;

    typedef struct packed {
        logic [31:0]        ax;
        logic               negx;
        logic [31:0]        ay;
        logic               negy;
        logic [31:0]        zc;
        logic signed [31:0] z;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } t_s0;

    function automatic t_div div_step(input t_div s);
        t_div        r;
        logic [32:0] trial;
        r     = s;
        trial = {s.rem, s.work[63]};
        if (trial >= {1'b0, s.d}) begin
            r.rem  = 32'(trial - {1'b0, s.d});
            r.work = {s.work[62:0], 1'b1};
        end else begin
            r.rem  = trial[31:0];
            r.work = {s.work[62:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [7:0] pack_normal(input logic signed [15:0] n);
        logic signed [24:0] t;
        logic [10:0]        q;
        t = 25'(n * 25'sd127) + 25'sd2080768;
        q = 11'(t >>> NORM_FRAC);
        if (t < 0) begin
            return 8'd0;
        end else if (q > 11'd255) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

endpackage

// ===== sv/vertex_project_and_clip.sv =====
// ----------------------------------------------------------------------------
// vertex_project_and_clip
// Perspective projection of camera-space vertices with clip outcodes.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one camera-space vertex per
// item; output channel (o_out_valid / i_out_ready) returns one result item
// per vertex, in order. The user writes registers through the APB port only
// while the block is idle; the block does not enforce it. pready is tied high.
// From acceptance to o_out_valid the path is one input stage, one multiply
// stage, 64 stages of a bit-per-stage restoring divider (x and y lanes in
// parallel), and three stages of rounding, saturation and clip test.
// Throughput is one item per cycle while the receiver does not stall; the divider depth sets the latency.
// The whole pipeline advances together: when the receiver stalls with a
// result waiting, every stage holds and o_in_ready drops; nothing is lost.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module vertex_project_and_clip #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_cam_x,
    input  logic signed [31:0]  i_cam_y,
    input  logic signed [31:0]  i_cam_z,
    input  logic signed [15:0]  i_norm_x,
    input  logic signed [15:0]  i_norm_y,
    input  logic signed [31:0]  i_tex_u,
    input  logic signed [31:0]  i_tex_v,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_screen_x,
    output logic signed [15:0]  o_screen_y,
    output logic signed [31:0]  o_depth,
    output logic [7:0]          o_normal_x_byte,
    output logic [7:0]          o_normal_y_byte,
    output logic signed [23:0]  o_texel_x,
    output logic signed [23:0]  o_texel_y,
    output logic [4:0]          o_clip_code,
    output logic                o_visible
);

    localparam int           NS        = vpc_pkg::DIV_STEPS;
    localparam logic [31:0]  MIN_DEPTH = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam int           SW        = 67;
    localparam int           CW        = 12 + FRAC_BITS;

    // registers
    logic [31:0] r_focal;
    logic [12:0] r_scr_w, r_scr_h, r_clip_w, r_clip_h, r_tex_w, r_tex_h;
    vpc_pkg::t_reg_idx w_idx;
    logic w_wr;

    assign pready = 1'b1;
    assign w_idx  = vpc_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= 32'd16777216;
            r_scr_w  <= 13'd320;
            r_scr_h  <= 13'd240;
            r_clip_w <= 13'd320;
            r_clip_h <= 13'd240;
            r_tex_w  <= 13'd256;
            r_tex_h  <= 13'd256;
        end else if (w_wr) begin
            case (w_idx)
                vpc_pkg::REG_FOCAL_SCALE:    r_focal  <= pwdata;
                vpc_pkg::REG_SCREEN_WIDTH:   r_scr_w  <= pwdata[12:0];
                vpc_pkg::REG_SCREEN_HEIGHT:  r_scr_h  <= pwdata[12:0];
                vpc_pkg::REG_CLIP_WIDTH:     r_clip_w <= pwdata[12:0];
                vpc_pkg::REG_CLIP_HEIGHT:    r_clip_h <= pwdata[12:0];
                vpc_pkg::REG_TEXTURE_WIDTH:  r_tex_w  <= pwdata[12:0];
                vpc_pkg::REG_TEXTURE_HEIGHT: r_tex_h  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            vpc_pkg::REG_FOCAL_SCALE:    prdata = r_focal;
            vpc_pkg::REG_SCREEN_WIDTH:   prdata = {19'd0, r_scr_w};
            vpc_pkg::REG_SCREEN_HEIGHT:  prdata = {19'd0, r_scr_h};
            vpc_pkg::REG_CLIP_WIDTH:     prdata = {19'd0, r_clip_w};
            vpc_pkg::REG_CLIP_HEIGHT:    prdata = {19'd0, r_clip_h};
            vpc_pkg::REG_TEXTURE_WIDTH:  prdata = {19'd0, r_tex_w};
            vpc_pkg::REG_TEXTURE_HEIGHT: prdata = {19'd0, r_tex_h};
            default:                     prdata = 32'd0;
        endcase
    end

    // pipeline control
    logic w_adv;
    logic r_v0;
    logic r_v [0:NS];
    logic r_vp1, r_vp2, r_vp3;

    assign w_adv       = !r_vp3 || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vp3;

    // stage 0: magnitudes and depth clamp
    vpc_pkg::t_s0 r_s0, n_s0;
    logic signed [32:0] w_nyv;

    always_comb begin
        w_nyv       = -33'(i_cam_y);
        n_s0.negx   = i_cam_x[31];
        n_s0.ax     = i_cam_x[31] ? 32'(-33'(i_cam_x)) : 32'(i_cam_x);
        n_s0.negy   = w_nyv[32];
        n_s0.ay     = w_nyv[32] ? 32'(-w_nyv) : w_nyv[31:0];
        n_s0.zc     = (i_cam_z > $signed(MIN_DEPTH)) ? 32'(i_cam_z) : MIN_DEPTH;
        n_s0.z      = i_cam_z;
        n_s0.nx     = i_norm_x;
        n_s0.ny     = i_norm_y;
        n_s0.u      = i_tex_u;
        n_s0.v      = i_tex_v;
    end

    // stage 1: products and side results
    vpc_pkg::t_div  r_dx [0:NS];
    vpc_pkg::t_div  r_dy [0:NS];
    vpc_pkg::t_side r_sd [0:NS];
    vpc_pkg::t_div  n_dx, n_dy;
    vpc_pkg::t_side n_sd;
    logic signed [45:0] w_pu, w_pv;
    logic signed [45:0] w_tu, w_tv;

    always_comb begin
        n_dx.rem  = 32'd0;
        n_dx.work = 64'(r_s0.ax) * 64'(r_focal);
        n_dx.d    = r_s0.zc;
        n_dx.neg  = r_s0.negx;
        n_dy.rem  = 32'd0;
        n_dy.work = 64'(r_s0.ay) * 64'(r_focal);
        n_dy.d    = r_s0.zc;
        n_dy.neg  = r_s0.negy;

        w_pu = 46'(r_s0.u) * $signed({33'd0, r_tex_w});
        w_pv = 46'(r_s0.v) * $signed({33'd0, r_tex_h});
        w_tu = (w_pu >>> FRAC_BITS) +
               $signed(46'(w_pu[45] && (w_pu[FRAC_BITS-1:0] != '0)));
        w_tv = (w_pv >>> FRAC_BITS) +
               $signed(46'(w_pv[45] && (w_pv[FRAC_BITS-1:0] != '0)));

        n_sd.z_neg = r_s0.z[31];
        n_sd.nbx   = vpc_pkg::pack_normal(r_s0.nx);
        n_sd.nby   = vpc_pkg::pack_normal(r_s0.ny);
        n_sd.tx    = (w_tu > 46'sd8388607)  ? 24'sh7FFFFF :
                     (w_tu < -46'sd8388608) ? 24'sh800000 : w_tu[23:0];
        n_sd.ty    = (w_tv > 46'sd8388607)  ? 24'sh7FFFFF :
                     (w_tv < -46'sd8388608) ? 24'sh800000 : w_tv[23:0];
        n_sd.depth = 32'(r_s0.z);
    end

    logic signed [31:0] n_sd_depth;

    generate
        if (FRAC_BITS <= 16) begin : g_dep_up
            logic signed [47:0] w_dz;
            assign w_dz = 48'(r_s0.z) <<< (16 - FRAC_BITS);
            always_comb begin
                n_sd_depth = (w_dz > 48'sh7FFFFFFF)           ? 32'sh7FFFFFFF :
                             (w_dz < -48'sh80000000)          ? 32'sh80000000 :
                             w_dz[31:0];
            end
        end else begin : g_dep_dn
            always_comb begin
                n_sd_depth = (r_s0.z >>> (FRAC_BITS - 16)) +
                             $signed(32'(r_s0.z[31] && (r_s0.z[FRAC_BITS-17:0] != '0)));
            end
        end
    endgenerate

    vpc_pkg::t_side w_sd0;
    always_comb begin
        w_sd0       = n_sd;
        w_sd0.depth = n_sd_depth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_v0   <= i_in_valid;
            r_v[0] <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0    <= n_s0;
            r_dx[0] <= n_dx;
            r_dy[0] <= n_dy;
            r_sd[0] <= w_sd0;
        end
    end

    // divider stages: one quotient bit each
    generate
        for (genvar k = 0; k < NS; k++) begin : g_div
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (w_adv) begin
                    r_v[k+1] <= r_v[k];
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dx[k+1] <= vpc_pkg::div_step(r_dx[k]);
                    r_dy[k+1] <= vpc_pkg::div_step(r_dy[k]);
                    r_sd[k+1] <= r_sd[k];
                end
            end
        end
    endgenerate

    // post 1: signed quotient plus centre
    logic signed [SW-1:0] r_sx, r_sy, n_sx, n_sy;
    logic                 r_fx, r_fy;
    vpc_pkg::t_side       r_sd1, r_sd2;
    logic signed [SW-1:0] w_cx, w_cy, w_qx, w_qy;
    logic                 w_fx, w_fy;

    always_comb begin
        w_fx = r_dx[NS].rem != 32'd0;
        w_fy = r_dy[NS].rem != 32'd0;
        w_qx = r_dx[NS].neg ? -$signed({3'd0, r_dx[NS].work}) - SW'(w_fx)
                            : $signed({3'd0, r_dx[NS].work});
        w_qy = r_dy[NS].neg ? -$signed({3'd0, r_dy[NS].work}) - SW'(w_fy)
                            : $signed({3'd0, r_dy[NS].work});
        w_cx = $signed(SW'({r_scr_w[12:1], {FRAC_BITS{1'b0}}}));
        w_cy = $signed(SW'({r_scr_h[12:1], {FRAC_BITS{1'b0}}}));
        n_sx = w_qx + w_cx;
        n_sy = w_qy + w_cy;
    end

    // post 2: truncate toward zero and saturate
    logic signed [15:0]   r_px, r_py, n_px, n_py;
    logic signed [SW-1:0] w_rx, w_ry;

    always_comb begin
        w_rx = (r_sx >>> FRAC_BITS) +
               $signed(SW'(r_sx[SW-1] && (r_fx || (r_sx[FRAC_BITS-1:0] != '0))));
        w_ry = (r_sy >>> FRAC_BITS) +
               $signed(SW'(r_sy[SW-1] && (r_fy || (r_sy[FRAC_BITS-1:0] != '0))));
        n_px = (w_rx > SW'(32767))  ? 16'sh7FFF :
               (w_rx < -SW'(32768)) ? 16'sh8000 : w_rx[15:0];
        n_py = (w_ry > SW'(32767))  ? 16'sh7FFF :
               (w_ry < -SW'(32768)) ? 16'sh8000 : w_ry[15:0];
    end

    // post 3: clip test into the output register
    logic [4:0] n_code;
    always_comb begin
        n_code[0] = r_px[15];
        n_code[1] = 17'(r_px) >= $signed({4'd0, r_clip_w});
        n_code[2] = r_py[15];
        n_code[3] = 17'(r_py) >= $signed({4'd0, r_clip_h});
        n_code[4] = r_sd2.z_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp1 <= 1'b0;
            r_vp2 <= 1'b0;
            r_vp3 <= 1'b0;
        end else if (w_adv) begin
            r_vp1 <= r_v[NS];
            r_vp2 <= r_vp1;
            r_vp3 <= r_vp2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sx            <= n_sx;
            r_sy            <= n_sy;
            r_fx            <= w_fx;
            r_fy            <= w_fy;
            r_sd1           <= r_sd[NS];
            r_px            <= n_px;
            r_py            <= n_py;
            r_sd2           <= r_sd1;
            o_screen_x      <= r_px;
            o_screen_y      <= r_py;
            o_depth         <= r_sd2.depth;
            o_normal_x_byte <= r_sd2.nbx;
            o_normal_y_byte <= r_sd2.nby;
            o_texel_x       <= r_sd2.tx;
            o_texel_y       <= r_sd2.ty;
            o_clip_code     <= n_code;
            o_visible       <= n_code == 5'd0;
        end
    end

endmodule

// ===== sv/vpc_checker.sv =====
// ----------------------------------------------------------------------------
// vpc_checker
// Port-level checks for the vertex projection and clip block.
// ----------------------------------------------------------------------------
module vpc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       pready,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [4:0] o_clip_code,
    input logic       o_visible
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_visible == (o_clip_code == 5'd0)))
        else $error("visible flag disagrees with clip code");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind vertex_project_and_clip vpc_checker u_vpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .pready      (pready),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_clip_code (o_clip_code),
    .o_visible   (o_visible)
);
